// ===== rtl/external_interrupt_priority_select_top_macros.svh =====
// Assertion macros for the external-interrupt priority selector.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef EXTERNAL_INTERRUPT_PRIORITY_SELECT_TOP_MACROS_SVH
`define EXTERNAL_INTERRUPT_PRIORITY_SELECT_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define EPSEL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("epsel: same-cycle check failed");
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define EPSEL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("epsel: next-cycle check failed");
`else
`define EPSEL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EPSEL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/epsel_pkg.sv =====
// Shared types, codes and helpers of the external-interrupt priority selector.
// No dependencies; used by the channel interfaces and the top level.
package epsel_pkg;

  // Number of CPUs that can originate malfunction alerts and emergency signals.
  localparam int CpuCount = 8;
  localparam int CpuVecW  = 8;
  localparam logic [CpuVecW-1:0] CpuVecMask =
    (CpuCount >= CpuVecW) ? {CpuVecW{1'b1}} : CpuVecW'((64'd1 << CpuCount) - 64'd1);

  // Field widths.
  localparam int OpW    = 3;
  localparam int CpuW   = 3;
  localparam int ParmW  = 32;
  localparam int TodW   = 64;
  localparam int ClassW = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 64;
  localparam int EnableW  = 8;

  // Item operation codes.
  typedef enum logic [OpW-1:0] {
    OP_CHECK     = 3'd0,
    OP_KEY       = 3'd1,
    OP_MALFUNC   = 3'd2,
    OP_EMERGENCY = 3'd3,
    OP_EXT_CALL  = 3'd4,
    OP_INTERVAL  = 3'd5,
    OP_SERVICE   = 3'd6
  } op_e;

  // Interrupt class codes; the code is also the enable bit index.
  typedef enum logic [ClassW-1:0] {
    CLS_KEY        = 3'd0,
    CLS_MALFUNC    = 3'd1,
    CLS_EMERGENCY  = 3'd2,
    CLS_EXT_CALL   = 3'd3,
    CLS_COMPARATOR = 3'd4,
    CLS_CPU_TIMER  = 3'd5,
    CLS_INTERVAL   = 3'd6,
    CLS_SERVICE    = 3'd7
  } class_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE_MASK = 2'd0,
    REG_CLOCK_COMP  = 2'd1
  } reg_idx_e;

  // Index of the lowest set bit of a CPU vector (zero for an empty vector).
  function automatic logic [CpuW-1:0] lowest_cpu(input logic [CpuVecW-1:0] vec);
    logic [CpuW-1:0] idx;
    idx = '0;
    for (int i = CpuVecW - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = CpuW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/epsel_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on epsel_pkg for the field widths.
interface epsel_in_if;
  logic                           valid;
  logic                           ready;
  logic [epsel_pkg::OpW-1:0]      op;
  logic [epsel_pkg::CpuW-1:0]     source_cpu;
  logic [epsel_pkg::ParmW-1:0]    service_parm;
  logic [epsel_pkg::TodW-1:0]     tod_value;
  logic signed [epsel_pkg::TodW-1:0] timer_value;

  modport source (output valid, op, source_cpu, service_parm, tod_value, timer_value,
                  input ready);
  modport sink (input valid, op, source_cpu, service_parm, tod_value, timer_value,
                output ready);
endinterface

interface epsel_out_if;
  logic                          valid;
  logic                          ready;
  logic                          taken;
  logic [epsel_pkg::ClassW-1:0]  int_class;
  logic [epsel_pkg::CpuW-1:0]    cpu_address;
  logic [epsel_pkg::ParmW-1:0]   parameter_res;

  modport source (output valid, taken, int_class, cpu_address, parameter_res,
                  input ready);
  modport sink (input valid, taken, int_class, cpu_address, parameter_res,
                output ready);
endinterface

// ===== rtl/external_interrupt_priority_select_top.sv =====
// External-interrupt priority selector: every input beat yields exactly one result
// beat. Raise beats latch a pending source and return an all-zero result; a check
// beat picks the highest-priority enabled source (key, malfunction, emergency,
// external call, comparator, CPU timer, interval timer, service), clears it unless
// it is the comparator or CPU timer, and reports class, source CPU and service
// parameter. An item passes the input register, then the result register; a beat is
// accepted every cycle unless the output stalls, as the pending-state update is
// combinational. The user must write configuration only while the block is idle;
// the block does not enforce it. Depends on epsel_pkg, epsel_if and the macro header.
`include "external_interrupt_priority_select_top_macros.svh"

module external_interrupt_priority_select_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  epsel_in_if.sink                           in_i,
  epsel_out_if.source                        out_o,
  input  logic                               cfg_we_i,
  input  logic [epsel_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [epsel_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int VecW = epsel_pkg::CpuVecW;

  // Configuration registers.
  logic [epsel_pkg::EnableW-1:0] enable_mask_q;
  logic [epsel_pkg::TodW-1:0]    clock_comp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_mask_q <= '0;
      clock_comp_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == epsel_pkg::REG_ENABLE_MASK) begin
        enable_mask_q <= cfg_data_i[epsel_pkg::EnableW-1:0];
      end else if (cfg_idx_i == epsel_pkg::REG_CLOCK_COMP) begin
        clock_comp_q <= cfg_data_i;
      end
    end
  end

  // Handshake control for the input register and the result register.
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, s1_fire, in_acc;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_acc     = in_i.valid && in_i.ready;
  assign s1_valid_d = in_acc || (s1_valid_q && !out_free);
  assign out_valid_d = s1_fire || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register holding the accepted beat.
  logic [epsel_pkg::OpW-1:0]   op_q;
  logic [epsel_pkg::CpuW-1:0]  src_q;
  logic [epsel_pkg::ParmW-1:0] parm_q;
  logic [epsel_pkg::TodW-1:0]  tod_q;
  logic                        timer_neg_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q        <= in_i.op;
      src_q       <= in_i.source_cpu;
      parm_q      <= in_i.service_parm;
      tod_q       <= in_i.tod_value;
      timer_neg_q <= in_i.timer_value[epsel_pkg::TodW-1];
    end
  end

  // Pending interrupt state.
  logic                        key_q, key_d;
  logic [VecW-1:0]             malf_q, malf_d;
  logic [VecW-1:0]             emer_q, emer_d;
  logic                        call_q, call_d;
  logic [epsel_pkg::CpuW-1:0]  call_src_q, call_src_d;
  logic                        intv_q, intv_d;
  logic                        serv_q, serv_d;
  logic [epsel_pkg::ParmW-1:0] serv_val_q, serv_val_d;

  // Result of the beat in the input register.
  logic                         taken_d;
  logic [epsel_pkg::ClassW-1:0] class_d;
  logic [epsel_pkg::CpuW-1:0]   cpu_d;
  logic [epsel_pkg::ParmW-1:0]  parm_res_d;

  logic [VecW-1:0]             malf_vec, emer_vec;
  logic [epsel_pkg::CpuW-1:0]  malf_low, emer_low;
  logic                        src_ok, comp_hit;

  assign malf_vec = malf_q & epsel_pkg::CpuVecMask;
  assign emer_vec = emer_q & epsel_pkg::CpuVecMask;
  assign malf_low = epsel_pkg::lowest_cpu(malf_vec);
  assign emer_low = epsel_pkg::lowest_cpu(emer_vec);
  assign src_ok   = epsel_pkg::CpuVecMask[src_q];
  assign comp_hit = tod_q > clock_comp_q;

  // Raise handling and priority selection.
  always_comb begin
    key_d      = key_q;
    malf_d     = malf_q;
    emer_d     = emer_q;
    call_d     = call_q;
    call_src_d = call_src_q;
    intv_d     = intv_q;
    serv_d     = serv_q;
    serv_val_d = serv_val_q;
    taken_d    = 1'b0;
    class_d    = '0;
    cpu_d      = '0;
    parm_res_d = '0;
    if (s1_fire) begin
      unique case (op_q)
        epsel_pkg::OP_CHECK: begin
          priority if (key_q && enable_mask_q[epsel_pkg::CLS_KEY]) begin
            key_d   = 1'b0;
            taken_d = 1'b1;
            class_d = epsel_pkg::CLS_KEY;
          end else if ((malf_vec != '0) && enable_mask_q[epsel_pkg::CLS_MALFUNC]) begin
            malf_d[malf_low] = 1'b0;
            taken_d = 1'b1;
            class_d = epsel_pkg::CLS_MALFUNC;
            cpu_d   = malf_low;
          end else if ((emer_vec != '0) && enable_mask_q[epsel_pkg::CLS_EMERGENCY]) begin
            emer_d[emer_low] = 1'b0;
            taken_d = 1'b1;
            class_d = epsel_pkg::CLS_EMERGENCY;
            cpu_d   = emer_low;
          end else if (call_q && enable_mask_q[epsel_pkg::CLS_EXT_CALL]) begin
            call_d  = 1'b0;
            taken_d = 1'b1;
            class_d = epsel_pkg::CLS_EXT_CALL;
            cpu_d   = call_src_q;
          end else if (comp_hit && enable_mask_q[epsel_pkg::CLS_COMPARATOR]) begin
            taken_d = 1'b1;
            class_d = epsel_pkg::CLS_COMPARATOR;
          end else if (timer_neg_q && enable_mask_q[epsel_pkg::CLS_CPU_TIMER]) begin
            taken_d = 1'b1;
            class_d = epsel_pkg::CLS_CPU_TIMER;
          end else if (intv_q && enable_mask_q[epsel_pkg::CLS_INTERVAL]) begin
            intv_d  = 1'b0;
            taken_d = 1'b1;
            class_d = epsel_pkg::CLS_INTERVAL;
          end else if (serv_q && enable_mask_q[epsel_pkg::CLS_SERVICE]) begin
            serv_d     = 1'b0;
            serv_val_d = '0;
            parm_res_d = serv_val_q;
            taken_d    = 1'b1;
            class_d    = epsel_pkg::CLS_SERVICE;
          end else begin
            taken_d = 1'b0;
          end
        end
        epsel_pkg::OP_KEY: begin
          key_d = 1'b1;
        end
        epsel_pkg::OP_MALFUNC: begin
          if (src_ok) begin
            malf_d[src_q] = 1'b1;
          end
        end
        epsel_pkg::OP_EMERGENCY: begin
          if (src_ok) begin
            emer_d[src_q] = 1'b1;
          end
        end
        epsel_pkg::OP_EXT_CALL: begin
          call_d     = 1'b1;
          call_src_d = src_q;
        end
        epsel_pkg::OP_INTERVAL: begin
          intv_d = 1'b1;
        end
        epsel_pkg::OP_SERVICE: begin
          serv_d     = 1'b1;
          serv_val_d = serv_val_q | parm_q;
        end
        default: begin
          // Unused operation code: no state change, all-zero result.
          taken_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= 1'b0;
      malf_q     <= '0;
      emer_q     <= '0;
      call_q     <= 1'b0;
      call_src_q <= '0;
      intv_q     <= 1'b0;
      serv_q     <= 1'b0;
      serv_val_q <= '0;
    end else begin
      key_q      <= key_d;
      malf_q     <= malf_d;
      emer_q     <= emer_d;
      call_q     <= call_d;
      call_src_q <= call_src_d;
      intv_q     <= intv_d;
      serv_q     <= serv_d;
      serv_val_q <= serv_val_d;
    end
  end

  // Result register.
  logic                         taken_q;
  logic [epsel_pkg::ClassW-1:0] class_q;
  logic [epsel_pkg::CpuW-1:0]   cpu_q;
  logic [epsel_pkg::ParmW-1:0]  parm_res_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      taken_q    <= taken_d;
      class_q    <= class_d;
      cpu_q      <= cpu_d;
      parm_res_q <= parm_res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.taken         = taken_q;
  assign out_o.int_class     = class_q;
  assign out_o.cpu_address   = cpu_q;
  assign out_o.parameter_res = parm_res_q;

  // A delivered interrupt belongs to an enabled class.
  `EPSEL_ASSERT_IMP(a_taken_enabled, clk_i, rst_ni,
    out_valid_q && taken_q, enable_mask_q[class_q])
  // A result that took nothing carries all-zero fields.
  `EPSEL_ASSERT_IMP(a_not_taken_zero, clk_i, rst_ni,
    out_valid_q && !taken_q, (class_q == '0) && (cpu_q == '0) && (parm_res_q == '0))
  // A nonzero parameter only comes with a taken service signal.
  `EPSEL_ASSERT_IMP(a_parm_service, clk_i, rst_ni,
    out_valid_q && (parm_res_q != '0),
    taken_q && (class_q == epsel_pkg::CLS_SERVICE))
  // Taking the interrupt key clears it.
  `EPSEL_ASSERT_NXT(a_key_cleared, clk_i, rst_ni,
    s1_fire && (op_q == epsel_pkg::OP_CHECK) && key_q
      && enable_mask_q[epsel_pkg::CLS_KEY],
    !key_q)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for external_interrupt_priority_select_top.
// Drives raise and check beats, predicts each result beat and compares them field by field.
// Depends on epsel_pkg, the channel interfaces in epsel_if and the top-level RTL.
`timescale 1ns / 100ps

module tb;

  localparam int OpW      = epsel_pkg::OpW;
  localparam int CpuW     = epsel_pkg::CpuW;
  localparam int ParmW    = epsel_pkg::ParmW;
  localparam int TodW     = epsel_pkg::TodW;
  localparam int CfgIdxW  = epsel_pkg::CfgIdxW;
  localparam int CfgDataW = epsel_pkg::CfgDataW;
  localparam int EnableW  = epsel_pkg::EnableW;
  localparam int CpuVecW  = epsel_pkg::CpuVecW;

  localparam int WatchdogLimit = 2000;
  localparam int LongHoldCycles = 300;
  localparam int DirRows = 24;

  // Operation code that the block leaves unused.
  localparam logic [OpW-1:0] OP_UNUSED = 3'd7;
  // Register indexes past the end of the register list.
  localparam logic [CfgIdxW-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]          op;
    logic [CpuW-1:0]         src;
    logic [ParmW-1:0]        parm;
    logic [TodW-1:0]         tod;
    logic signed [TodW-1:0]  timer;
  } irq_item_t;

  typedef struct packed {
    logic              taken;
    epsel_pkg::class_e cls;
    logic [CpuW-1:0]   cpu;
    logic [ParmW-1:0]  parm;
  } irq_res_t;

  typedef struct packed {
    irq_item_t item;
    logic      fixed;
    irq_res_t  res;
  } dir_row_t;

  localparam irq_res_t NO_IRQ = '{1'b0, epsel_pkg::CLS_KEY, 3'd0, 32'd0};

  localparam logic signed [TodW-1:0] TIMER_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [TodW-1:0] TIMER_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [TodW-1:0] TOD_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  epsel_in_if  in_ch ();
  epsel_out_if out_ch ();

  external_interrupt_priority_select_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Directed beats, run with key disabled and the comparator at 1000. Rows with
  // fixed set carry their result; the others are checked against the predictor.
  dir_row_t dir_tab [DirRows] = '{
    '{'{epsel_pkg::OP_CHECK, 3'd0, 32'd0, 64'd0, 64'sd0}, 1'b1, NO_IRQ},
    '{'{OP_UNUSED, 3'd7, 32'hFFFF_FFFF, TOD_MAX, TIMER_MIN}, 1'b1, NO_IRQ},
    '{'{epsel_pkg::OP_KEY, 3'd0, 32'd0, 64'd0, 64'sd0}, 1'b1, NO_IRQ},
    '{'{epsel_pkg::OP_MALFUNC, 3'd7, 32'd0, TOD_MAX, -64'sd1}, 1'b1, NO_IRQ},
    '{'{epsel_pkg::OP_MALFUNC, 3'd2, 32'd0, 64'd0, 64'sd0}, 1'b1, NO_IRQ},
    '{'{epsel_pkg::OP_EMERGENCY, 3'd0, 32'd0, 64'd0, 64'sd0}, 1'b1, NO_IRQ},
    '{'{epsel_pkg::OP_EMERGENCY, 3'd5, 32'd0, 64'd0, 64'sd0}, 1'b1, NO_IRQ},
    '{'{epsel_pkg::OP_EXT_CALL, 3'd3, 32'd0, 64'd0, 64'sd0}, 1'b1, NO_IRQ},
    '{'{epsel_pkg::OP_EXT_CALL, 3'd6, 32'd0, 64'd0, 64'sd0}, 1'b1, NO_IRQ},
    '{'{epsel_pkg::OP_INTERVAL, 3'd0, 32'd0, 64'd0, 64'sd0}, 1'b1, NO_IRQ},
    '{'{epsel_pkg::OP_SERVICE, 3'd0, 32'hFFFF_0000, 64'd0, 64'sd0}, 1'b1, NO_IRQ},
    '{'{epsel_pkg::OP_SERVICE, 3'd0, 32'h0000_FFFF, 64'd0, 64'sd0}, 1'b1, NO_IRQ},
    '{'{epsel_pkg::OP_CHECK, 3'd0, 32'd0, 64'd0, 64'sd0}, 1'b1,
      '{1'b1, epsel_pkg::CLS_MALFUNC, 3'd2, 32'd0}},
    '{'{epsel_pkg::OP_CHECK, 3'd0, 32'd0, 64'd0, 64'sd0}, 1'b1,
      '{1'b1, epsel_pkg::CLS_MALFUNC, 3'd7, 32'd0}},
    '{'{epsel_pkg::OP_CHECK, 3'd0, 32'd0, 64'd0, 64'sd0}, 1'b1,
      '{1'b1, epsel_pkg::CLS_EMERGENCY, 3'd0, 32'd0}},
    '{'{epsel_pkg::OP_CHECK, 3'd0, 32'd0, 64'd0, 64'sd0}, 1'b1,
      '{1'b1, epsel_pkg::CLS_EMERGENCY, 3'd5, 32'd0}},
    '{'{epsel_pkg::OP_CHECK, 3'd0, 32'd0, 64'd0, 64'sd0}, 1'b1,
      '{1'b1, epsel_pkg::CLS_EXT_CALL, 3'd6, 32'd0}},
    '{'{epsel_pkg::OP_CHECK, 3'd0, 32'd0, TOD_MAX, -64'sd1}, 1'b1,
      '{1'b1, epsel_pkg::CLS_COMPARATOR, 3'd0, 32'd0}},
    '{'{epsel_pkg::OP_CHECK, 3'd0, 32'd0, 64'd1000, TIMER_MIN}, 1'b1,
      '{1'b1, epsel_pkg::CLS_CPU_TIMER, 3'd0, 32'd0}},
    '{'{epsel_pkg::OP_CHECK, 3'd0, 32'd0, 64'd1000, TIMER_MAX}, 1'b1,
      '{1'b1, epsel_pkg::CLS_INTERVAL, 3'd0, 32'd0}},
    '{'{epsel_pkg::OP_CHECK, 3'd0, 32'd0, 64'd0, 64'sd0}, 1'b1,
      '{1'b1, epsel_pkg::CLS_SERVICE, 3'd0, 32'hFFFF_FFFF}},
    '{'{epsel_pkg::OP_CHECK, 3'd0, 32'd0, 64'd0, 64'sd0}, 1'b1, NO_IRQ},
    '{'{epsel_pkg::OP_SERVICE, 3'd0, 32'd0, 64'd0, 64'sd0}, 1'b0, NO_IRQ},
    '{'{epsel_pkg::OP_CHECK, 3'd0, 32'd0, 64'd1001, 64'sd0}, 1'b0, NO_IRQ}
  };

  // Predictor copy of the configuration and the pending sources.
  logic [EnableW-1:0] en_mask;
  logic [TodW-1:0]    comp_val;
  logic               key_pend;
  logic [CpuVecW-1:0] malf_vec;
  logic [CpuVecW-1:0] emer_vec;
  logic               call_pend;
  logic [CpuW-1:0]    call_cpu;
  logic               intv_pend;
  logic               svc_pend;
  logic [ParmW-1:0]   svc_parm_acc;

  irq_res_t irq_exp_q [$];
  int err_cnt = 0;
  int quiet_cycles = 0;
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  bit long_hold_req = 1'b0;

  // Clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Lowest CPU number set in a per-CPU vector.
  function automatic logic [CpuW-1:0] first_cpu(input logic [CpuVecW-1:0] vec);
    logic [CpuW-1:0] idx;
    idx = '0;
    for (int i = 0; i < CpuVecW; i++) begin
      if (vec[i]) begin
        idx = CpuW'(i);
        break;
      end
    end
    return idx;
  endfunction

  // Applies one beat to the pending sources and returns the result it yields.
  function automatic irq_res_t predict_irq(input irq_item_t it);
    irq_res_t r;
    logic [CpuVecW-1:0] mv;
    logic [CpuVecW-1:0] ev;
    logic src_ok;
    r = NO_IRQ;
    mv = malf_vec & epsel_pkg::CpuVecMask;
    ev = emer_vec & epsel_pkg::CpuVecMask;
    src_ok = epsel_pkg::CpuVecMask[it.src];
    case (it.op)
      epsel_pkg::OP_CHECK: begin
        if (key_pend && en_mask[epsel_pkg::CLS_KEY]) begin
          key_pend = 1'b0;
          r.taken = 1'b1;
          r.cls = epsel_pkg::CLS_KEY;
        end else if (mv != '0 && en_mask[epsel_pkg::CLS_MALFUNC]) begin
          r.cpu = first_cpu(mv);
          malf_vec[r.cpu] = 1'b0;
          r.taken = 1'b1;
          r.cls = epsel_pkg::CLS_MALFUNC;
        end else if (ev != '0 && en_mask[epsel_pkg::CLS_EMERGENCY]) begin
          r.cpu = first_cpu(ev);
          emer_vec[r.cpu] = 1'b0;
          r.taken = 1'b1;
          r.cls = epsel_pkg::CLS_EMERGENCY;
        end else if (call_pend && en_mask[epsel_pkg::CLS_EXT_CALL]) begin
          call_pend = 1'b0;
          r.cpu = call_cpu;
          r.taken = 1'b1;
          r.cls = epsel_pkg::CLS_EXT_CALL;
        end else if (it.tod > comp_val && en_mask[epsel_pkg::CLS_COMPARATOR]) begin
          r.taken = 1'b1;
          r.cls = epsel_pkg::CLS_COMPARATOR;
        end else if (it.timer[TodW-1] && en_mask[epsel_pkg::CLS_CPU_TIMER]) begin
          r.taken = 1'b1;
          r.cls = epsel_pkg::CLS_CPU_TIMER;
        end else if (intv_pend && en_mask[epsel_pkg::CLS_INTERVAL]) begin
          intv_pend = 1'b0;
          r.taken = 1'b1;
          r.cls = epsel_pkg::CLS_INTERVAL;
        end else if (svc_pend && en_mask[epsel_pkg::CLS_SERVICE]) begin
          r.parm = svc_parm_acc;
          svc_parm_acc = '0;
          svc_pend = 1'b0;
          r.taken = 1'b1;
          r.cls = epsel_pkg::CLS_SERVICE;
        end
      end
      epsel_pkg::OP_KEY: key_pend = 1'b1;
      epsel_pkg::OP_MALFUNC: if (src_ok) malf_vec[it.src] = 1'b1;
      epsel_pkg::OP_EMERGENCY: if (src_ok) emer_vec[it.src] = 1'b1;
      epsel_pkg::OP_EXT_CALL: begin
        call_pend = 1'b1;
        call_cpu = it.src;
      end
      epsel_pkg::OP_INTERVAL: intv_pend = 1'b1;
      epsel_pkg::OP_SERVICE: begin
        svc_pend = 1'b1;
        svc_parm_acc = svc_parm_acc | it.parm;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random beat: mostly checks and raises, a few unused codes, clock values
  // clustered around the comparator so that both sides of the compare occur.
  function automatic irq_item_t rand_item();
    irq_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) it.op = epsel_pkg::OP_CHECK;
    else if (pick < 51) it.op = epsel_pkg::OP_KEY;
    else if (pick < 61) it.op = epsel_pkg::OP_MALFUNC;
    else if (pick < 71) it.op = epsel_pkg::OP_EMERGENCY;
    else if (pick < 79) it.op = epsel_pkg::OP_EXT_CALL;
    else if (pick < 87) it.op = epsel_pkg::OP_INTERVAL;
    else if (pick < 97) it.op = epsel_pkg::OP_SERVICE;
    else it.op = OP_UNUSED;
    it.src = CpuW'($urandom_range(0, 7));
    it.parm = $urandom_range(0, 1) ? $urandom : (32'd1 << $urandom_range(0, 31));
    case ($urandom_range(0, 5))
      0: it.tod = comp_val;
      1: it.tod = comp_val + 64'd1;
      2: it.tod = comp_val - 64'd1;
      3: it.tod = '0;
      4: it.tod = TOD_MAX;
      default: it.tod = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 4))
      0: it.timer = 64'sd0;
      1: it.timer = -64'sd1;
      2: it.timer = TIMER_MIN;
      3: it.timer = TIMER_MAX;
      default: it.timer = {$urandom, $urandom};
    endcase
    return it;
  endfunction

  // Register write: one cycle of write enable, then a wait with write enable low.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == epsel_pkg::REG_ENABLE_MASK) begin
      en_mask = data[EnableW-1:0];
    end else if (idx == epsel_pkg::REG_CLOCK_COMP) begin
      comp_val = data;
    end
    @(posedge clk_i);
  endtask

  // Offers one beat, waits for its acceptance and queues the expected result.
  task automatic send_beat(input irq_item_t it, input logic fixed, input irq_res_t fixed_res);
    irq_res_t r;
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= it.op;
    in_ch.source_cpu <= it.src;
    in_ch.service_parm <= it.parm;
    in_ch.tod_value <= it.tod;
    in_ch.timer_value <= it.timer;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    r = predict_irq(it);
    irq_exp_q.push_back(fixed ? fixed_res : r);
  endtask

  // Stops offering and waits until every result beat is back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (irq_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One random phase under a given configuration.
  task automatic run_phase(input logic [CfgDataW-1:0] mask_word,
                           input logic [CfgDataW-1:0] comp_word,
                           input int n_items, input bit idle, input bit hold);
    write_reg(epsel_pkg::REG_ENABLE_MASK, mask_word);
    write_reg(epsel_pkg::REG_CLOCK_COMP, comp_word);
    tx_idle_en = idle;
    rx_idle_en = idle;
    for (int i = 0; i < n_items; i++) begin
      if (hold && i == 100) long_hold_req = 1'b1;
      send_beat(rand_item(), 1'b0, NO_IRQ);
    end
    drain();
  endtask

  // Result receiver: random stall bursts and one long hold-off on request.
  initial begin
    int stall_cnt;
    stall_cnt = 0;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_cnt = LongHoldCycles;
        out_ch.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        if (stall_cnt == 0) out_ch.ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        stall_cnt = $urandom_range(1, 16);
        out_ch.ready <= 1'b0;
      end
    end
  end

  // Result checker: each accepted result beat against the oldest expectation.
  always @(posedge clk_i) begin
    irq_res_t e;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (irq_exp_q.size() == 0) begin
        $error("unexpected result beat: taken %0d, int_class %0d", out_ch.taken,
               out_ch.int_class);
        err_cnt++;
      end else begin
        e = irq_exp_q.pop_front();
        if (out_ch.taken !== e.taken) begin
          $error("taken: expected %0d, actual %0d", e.taken, out_ch.taken);
          err_cnt++;
        end
        if (out_ch.int_class !== e.cls) begin
          $error("int_class: expected %0d, actual %0d", e.cls, out_ch.int_class);
          err_cnt++;
        end
        if (out_ch.cpu_address !== e.cpu) begin
          $error("cpu_address: expected %0d, actual %0d", e.cpu, out_ch.cpu_address);
          err_cnt++;
        end
        if (out_ch.parameter_res !== e.parm) begin
          $error("parameter_res: expected %h, actual %h", e.parm, out_ch.parameter_res);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= epsel_pkg::REG_ENABLE_MASK;
    cfg_data_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.op <= epsel_pkg::OP_CHECK;
    in_ch.source_cpu <= '0;
    in_ch.service_parm <= '0;
    in_ch.tod_value <= '0;
    in_ch.timer_value <= '0;
    en_mask = '0;
    comp_val = '0;
    key_pend = 1'b0;
    malf_vec = '0;
    emer_vec = '0;
    call_pend = 1'b0;
    call_cpu = '0;
    intv_pend = 1'b0;
    svc_pend = 1'b0;
    svc_parm_acc = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: key disabled so it stays pending without blocking the rest.
    write_reg(epsel_pkg::REG_ENABLE_MASK, 64'hFE);
    write_reg(epsel_pkg::REG_CLOCK_COMP, 64'd1000);
    for (int i = 0; i < DirRows; i++) begin
      send_beat(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].res);
    end
    drain();

    // Writes past the register list must leave the configuration alone.
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, 64'h0123_4567_89AB_CDEF);

    // Random phases: all enabled with the comparator at zero (and the long
    // hold-off), all disabled via high garbage bits, two random settings, and
    // a final all-enabled run at the top comparator value without idling.
    run_phase(64'hFF, 64'd0, 250, 1'b1, 1'b1);
    run_phase(64'hFFFF_FFFF_FFFF_FF00, '1, 150, 1'b1, 1'b0);
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 300, 1'b1, 1'b0);
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 300, 1'b1, 1'b0);
    run_phase(64'hFF, '1, 250, 1'b0, 1'b0);

    if (err_cnt == 0 && irq_exp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
